>>> design/u8u16_pkg.sv
// Shared types and codes for the UTF-8 to UTF-16 transcoder.
`default_nettype none

package u8u16_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned UNIT_W  = 16;
	localparam int unsigned POINT_W = 21;

	typedef enum logic [1:0] {
		KIND_UNIT = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		kind_t             kind;
		logic              last_of_run;
	} result_t;

	// Up to two results come out of one byte; count says how many are real.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} result_pair_t;

endpackage

`default_nettype wire

>>> design/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder, output buffer.
//
// Takes one UTF-8 byte per request on the slave side and gives UTF-16 code
// units, end-of-string and error results on the master side. A byte is taken
// every cycle while the master side keeps up. A byte that completes a point
// above 0xFFFF gives a surrogate pair. The second unit of the pair waits in a
// spill register, so the byte behind it waits in the input register until
// the spill register is empty. Bytes that give no result still pass through
// the input register. A result passes the input register and then the output
// register on its way to the master side; the decoder's result loads the output
// register when the byte advances. After an end or an error, bytes are dropped
// until one arrives with start_of_string set.
`default_nettype none

module utf8_to_utf16_transcoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire logic        s_axis_tuser,   // [0] start_of_string
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [15:0] code_unit
	output logic [1:0]       m_axis_tuser,   // [1:0] kind
	output logic             m_axis_tlast    // last_of_run
);
	import u8u16_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              sos_s1;
	logic              room, advance;
	result_pair_t      res;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			sos_s1  <= s_axis_tuser;
		end
	end

	u8u16_decoder u_decoder (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.in_byte         (byte_s1),
		.start_of_string (sos_s1),
		.res             (res)
	);

	u8u16_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (advance),
		.res           (res),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

>>> design/u8u16_decoder.sv
// Decoder state and the per-byte decode into zero, one or two UTF-16 results.
`default_nettype none

module u8u16_decoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [u8u16_pkg::BYTE_W-1:0]   in_byte,
	input  wire logic                           start_of_string,
	output u8u16_pkg::result_pair_t             res
);
	import u8u16_pkg::*;

	logic [POINT_W-1:0] point_q;
	logic [1:0]         pend_q;
	logic               halted_q;

	logic [POINT_W-1:0] point_eff, point_d, point_shift, point_done, point_off;
	logic [1:0]         pend_eff, pend_d, pend_dec;
	logic               halted_eff, halted_d;
	logic               finish;
	result_pair_t       res_d;

	always_comb begin
		point_eff  = start_of_string ? '0 : point_q;
		pend_eff   = start_of_string ? '0 : pend_q;
		halted_eff = start_of_string ? 1'b0 : halted_q;

		point_d    = point_eff;
		pend_d     = pend_eff;
		halted_d   = halted_eff;
		finish     = 1'b0;
		point_done = '0;
		res_d      = '0;

		point_shift = {point_eff[POINT_W-7:0], in_byte[5:0]};
		pend_dec    = pend_eff - 2'd1;

		if (!halted_eff) begin
			if (pend_eff == 2'd0) begin
				unique casez (in_byte)
					8'b0???????: begin
						finish     = 1'b1;
						point_done = {{(POINT_W-7){1'b0}}, in_byte[6:0]};
					end
					8'b110?????: begin
						point_d = {{(POINT_W-5){1'b0}}, in_byte[4:0]};
						pend_d  = 2'd1;
					end
					8'b1110????: begin
						point_d = {{(POINT_W-4){1'b0}}, in_byte[3:0]};
						pend_d  = 2'd2;
					end
					8'b11110???: begin
						point_d = {{(POINT_W-3){1'b0}}, in_byte[2:0]};
						pend_d  = 2'd3;
					end
					default: begin
						halted_d     = 1'b1;
						pend_d       = '0;
						point_d      = '0;
						res_d.count  = 2'd1;
						res_d.r0     = '{code_unit: '0, kind: KIND_ERR, last_of_run: 1'b1};
					end
				endcase
			end else if (in_byte[7:6] != 2'b10) begin
				// A stray byte inside a sequence drops the partial point.
				halted_d    = 1'b1;
				pend_d      = '0;
				point_d     = '0;
				res_d.count = 2'd1;
				res_d.r0    = '{code_unit: '0, kind: KIND_ERR, last_of_run: 1'b1};
			end else begin
				pend_d = pend_dec;
				if (pend_dec == 2'd0) begin
					point_d    = '0;
					finish     = 1'b1;
					point_done = point_shift;
				end else begin
					point_d = point_shift;
				end
			end
		end

		// Points above the BMP are offset and split; the offset wraps at 21 bits,
		// so out-of-range points keep only ten payload bits per surrogate.
		point_off = point_done - POINT_W'(32'h10000);
		if (finish) begin
			if (point_done == '0) begin
				halted_d    = 1'b1;
				pend_d      = '0;
				point_d     = '0;
				res_d.count = 2'd1;
				res_d.r0    = '{code_unit: '0, kind: KIND_END, last_of_run: 1'b1};
			end else if (point_done[POINT_W-1:UNIT_W] != '0) begin
				res_d.count = 2'd2;
				res_d.r0    = '{code_unit: {6'b110110, point_off[19:10]}, kind: KIND_UNIT,
					last_of_run: 1'b0};
				res_d.r1    = '{code_unit: {6'b110111, point_off[9:0]}, kind: KIND_UNIT,
					last_of_run: 1'b1};
			end else begin
				res_d.count = 2'd1;
				res_d.r0    = '{code_unit: point_done[UNIT_W-1:0], kind: KIND_UNIT,
					last_of_run: 1'b1};
			end
		end
	end

	assign res = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q  <= '0;
			pend_q   <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			point_q  <= point_d;
			pend_q   <= pend_d;
			halted_q <= halted_d;
		end
	end

	a_halted_clean: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> (pend_q == 2'd0 && point_q == '0))
		else $error("halted decoder holds a partial point");

	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.count == 2'd2) |->
		(res.r0.kind == KIND_UNIT && !res.r0.last_of_run && res.r1.last_of_run))
		else $error("surrogate pair badly marked");

	a_halt_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.count == 2'd1 && res.r0.kind != KIND_UNIT) |=> halted_q)
		else $error("end or error did not halt the decoder");

endmodule

`default_nettype wire

>>> design/u8u16_out_buf.sv
// Output register with a spill register for the second unit of a surrogate pair.
`default_nettype none

module u8u16_out_buf (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire u8u16_pkg::result_pair_t      res,
	output logic                              room,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [u8u16_pkg::UNIT_W-1:0]      m_axis_tdata,   // [15:0] code_unit
	output logic [1:0]                        m_axis_tuser,   // [1:0] kind
	output logic                              m_axis_tlast
);
	import u8u16_pkg::*;

	result_t out_q, spill_q;
	logic    out_v_q, spill_v_q;
	logic    take;

	assign take = out_v_q && m_axis_tready;
	// Room for a full pair: spill empty and the output slot free this cycle.
	assign room = !spill_v_q && (!out_v_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spill_v_q <= 1'b0;
		end else if (spill_v_q) begin
			if (take) begin
				out_v_q   <= 1'b1;
				spill_v_q <= 1'b0;
			end
		end else if (push && res.count != 2'd0) begin
			out_v_q   <= 1'b1;
			spill_v_q <= (res.count == 2'd2);
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spill_v_q) begin
			if (take) begin
				out_q <= spill_q;
			end
		end else if (push && res.count != 2'd0) begin
			out_q   <= res.r0;
			spill_q <= res.r1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q.code_unit;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last_of_run;

	a_spill_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		spill_v_q |-> out_v_q)
		else $error("spill register filled ahead of output register");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result pushed without room");

	a_pair_spills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.count == 2'd2) |=> (spill_v_q && !out_q.last_of_run))
		else $error("second surrogate unit not held");

endmodule

`default_nettype wire

>>> verif/utf8_to_utf16_transcoder_top_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder top level.
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_top_tb;

	import u8u16_pkg::*;

	// Tracks decoder state on accepted requests and holds the code units still due.
	class utf16_scoreboard;
		logic [POINT_W-1:0] acc_point = '0;
		logic [1:0]         cont_left = '0;
		logic               stopped   = 1'b0;
		result_t            due_q[$];
		int unsigned        failures  = 0;
		int unsigned        units_seen = 0;
		int unsigned        ends_seen  = 0;
		int unsigned        errs_seen  = 0;

		function void push_unit(logic [UNIT_W-1:0] unit, kind_t kind, logic last);
			result_t r;
			r.code_unit   = unit;
			r.kind        = kind;
			r.last_of_run = last;
			due_q.push_back(r);
		endfunction

		function void close_string(kind_t kind);
			stopped   = 1'b1;
			cont_left = '0;
			acc_point = '0;
			push_unit('0, kind, 1'b1);
		endfunction

		function void emit_point(logic [POINT_W-1:0] point);
			logic [POINT_W-1:0] offs;
			offs = point - 21'h10000;
			if (point == '0) begin
				close_string(KIND_END);
			end else if (point > 21'hFFFF) begin
				// The subtraction wraps at 21 bits, so points past the last plane keep
				// only the low twenty bits of the offset.
				push_unit({6'b110110, offs[19:10]}, KIND_UNIT, 1'b0);
				push_unit({6'b110111, offs[9:0]}, KIND_UNIT, 1'b1);
			end else begin
				push_unit(point[UNIT_W-1:0], KIND_UNIT, 1'b1);
			end
		endfunction

		// Returns 1 when the byte was decoded rather than dropped.
		function bit note_request(logic [7:0] b, logic sos);
			logic [POINT_W-1:0] done_point;
			if (sos) begin
				acc_point = '0;
				cont_left = '0;
				stopped   = 1'b0;
			end
			if (stopped)
				return 1'b0;
			if (cont_left == 2'd0) begin
				if (!b[7]) begin
					emit_point({14'd0, b[6:0]});
				end else if (b[7:5] == 3'b110) begin
					acc_point = {16'd0, b[4:0]};
					cont_left = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					acc_point = {17'd0, b[3:0]};
					cont_left = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					acc_point = {18'd0, b[2:0]};
					cont_left = 2'd3;
				end else begin
					close_string(KIND_ERR);
				end
			end else if (b[7:6] != 2'b10) begin
				close_string(KIND_ERR);
			end else begin
				acc_point = {acc_point[POINT_W-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					done_point = acc_point;
					acc_point  = '0;
					emit_point(done_point);
				end
			end
			return 1'b1;
		endfunction

		function void check_result(logic [UNIT_W-1:0] unit, logic [1:0] kind, logic last);
			result_t exp_r;
			if (due_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: unit %h kind %0d last %b", unit, kind, last);
				return;
			end
			exp_r = due_q.pop_front();
			case (exp_r.kind)
				KIND_UNIT: units_seen++;
				KIND_END:  ends_seen++;
				default:   errs_seen++;
			endcase
			if (exp_r.code_unit !== unit || exp_r.kind !== kind_t'(kind)
					|| exp_r.last_of_run !== last) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected unit %h kind %0d last %b, got unit %h kind %0d last %b",
						exp_r.code_unit, exp_r.kind, exp_r.last_of_run, unit, kind, last);
			end
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
	logic        s_axis_tuser  = 1'b0; // [0] start_of_string
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [15:0] code_unit
	logic [1:0]  m_axis_tuser;         // [1:0] kind
	logic        m_axis_tlast;

	utf16_scoreboard sb;
	int unsigned     send_idle_pct  = 0;
	int unsigned     recv_stall_pct = 0;
	int unsigned     decoded_count  = 0;

	utf8_to_utf16_transcoder_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Holds one request until it is taken, then maybe leaves a gap after it.
	task automatic send_byte(input logic [7:0] b, input logic sos);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= sos;
		do @(posedge clk); while (!s_axis_tready);
		if (sb.note_request(b, sos))
			decoded_count++;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Mostly well-formed characters with random payloads, plus some stray bytes.
	task automatic send_random_string();
		int unsigned n_chars;
		int unsigned len;
		logic        first;
		n_chars = $urandom_range(1, 12);
		first   = 1'b1;
		for (int c = 0; c < n_chars; c++) begin
			if ($urandom_range(99) < 6) begin
				send_byte(8'($urandom_range(255)), first | ($urandom_range(9) == 0));
			end else begin
				len = $urandom_range(1, 4);
				case (len)
					1: send_byte(8'($urandom_range(1, 127)), first);
					2: send_byte(8'hC0 | 8'($urandom_range(31)), first);
					3: send_byte(8'hE0 | 8'($urandom_range(15)), first);
					default: send_byte(8'hF0 | 8'($urandom_range(7)), first);
				endcase
				for (int k = 1; k < len; k++)
					send_byte(8'h80 | 8'($urandom_range(63)), 1'b0);
			end
			first = 1'b0;
		end
		if ($urandom_range(99) < 70)
			send_byte(8'h00, 1'b0);
	endtask

	initial begin
		int unsigned target;
		sb = new;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each sequence length, surrogate pairs, the largest point,
		// surrogate points passing through, end, dropped bytes and bad bytes.
		send_byte(8'h41, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
		send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hF8, 1'b1);
		send_byte(8'hE2, 1'b1); send_byte(8'h41, 1'b0);
		send_byte(8'hC0, 1'b1); send_byte(8'h80, 1'b0);
		send_byte(8'hF0, 1'b1); send_byte(8'h00, 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			target = decoded_count + 375;
			while (decoded_count < target)
				send_random_string();
		end
		s_axis_tvalid <= 1'b0;

		while (sb.due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Decoded %0d bytes over four pacing phases of sender gaps and receiver stalls.",
			decoded_count);
		$display("Checked %0d code units, %0d string ends and %0d encoding errors.",
			sb.units_seen, sb.ends_seen, sb.errs_seen);
		if (sb.failures == 0 && sb.due_q.size() == 0) begin
			$display("[utf8_to_utf16_transcoder_top] OK");
		end else begin
			$display("%0d failures, %0d results never arrived", sb.failures, sb.due_q.size());
			$display("[utf8_to_utf16_transcoder_top] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("[utf8_to_utf16_transcoder_top] ERROR");
		$finish;
	end

endmodule
